// ===== src/bcmc_pkg.sv =====
// ----------------------------------------------------------------------------
// Block cipher mode chain package
// Shared types and constants: item and result transactions, mode codes and
// configuration register indexes.
// ----------------------------------------------------------------------------
package bcmc_pkg;

    localparam int BLOCK_BYTES = 8;
    localparam int DATA_W      = 64;
    localparam int COUNT_W     = 4;
    localparam int CFG_IDX_W   = 2;

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(BLOCK_BYTES);
    localparam logic [7:0]         BYTE_ONES  = 8'hFF;

    typedef enum logic [2:0] {
        MODE_ECB  = 3'd0,
        MODE_CBC  = 3'd1,
        MODE_PCBC = 3'd2,
        MODE_CFB  = 3'd3,
        MODE_OFB  = 3'd4,
        MODE_CTR  = 3'd5
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE    = 2'd0,
        CFG_DECRYPT = 2'd1,
        CFG_KEY     = 2'd2,
        CFG_IV      = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [DATA_W-1:0]  data_block;
        logic [COUNT_W-1:0] valid_bytes;
        logic               restart;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0]  result_block;
        logic [COUNT_W-1:0] result_bytes;
    } result_t;

endpackage

// ===== src/block_cipher_mode_chain.sv =====
// Latency: a result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle; the chain register and the block counter
// update in the same cycle that takes the item, closing the feedback loop.
// Items are refused only while the result register is full and stalled.
// Reset (rst_n low, asynchronous) clears all registers but the result data.
// ----------------------------------------------------------------------------
// Block cipher mode chain
// ECB, CBC, PCBC, CFB, OFB and CTR chaining around an XOR-with-key cipher,
// one 8-byte block per transaction, with a registered result stage.
// ----------------------------------------------------------------------------
module block_cipher_mode_chain
    import bcmc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 item_valid,
    output logic                 item_stall,
    input  item_t                item,

    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    mode_t              mode_reg;
    logic               decrypt_reg;
    logic [DATA_W-1:0]  key_reg;
    logic [DATA_W-1:0]  iv_reg;

    logic [DATA_W-1:0]  chain_reg;
    logic [DATA_W-1:0]  chain_next;
    logic [DATA_W-1:0]  counter_reg;
    logic [DATA_W-1:0]  counter_next;

    logic               result_valid_reg;
    result_t            result_reg;
    result_t            result_next;

    logic               accept;
    logic [COUNT_W-1:0] count_eff;
    logic [DATA_W-1:0]  byte_mask;
    logic [DATA_W-1:0]  chain_cur;
    logic [DATA_W-1:0]  counter_cur;

    assign cfg_ready    = 1'b1;
    assign item_stall   = result_valid_reg & result_stall;
    assign accept       = item_valid & ~item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_ECB;
            decrypt_reg <= 1'b0;
            key_reg     <= '0;
            iv_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_MODE:    mode_reg    <= mode_t'(cfg_data[2:0]);
                CFG_DECRYPT: decrypt_reg <= cfg_data[0];
                CFG_KEY:     key_reg     <= cfg_data;
                CFG_IV:      iv_reg      <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Clamp the byte count to 1..BLOCK_BYTES and build the low-byte mask
    always_comb
    begin
        count_eff = item.valid_bytes;
        if (count_eff == '0)
        begin
            count_eff = COUNT_W'(1);
        end
        if (count_eff > FULL_COUNT)
        begin
            count_eff = FULL_COUNT;
        end
        for (int j = 0; j < BLOCK_BYTES; j++)
        begin
            byte_mask[8*j +: 8] = (COUNT_W'(j) < count_eff) ? BYTE_ONES : 8'h00;
        end
    end

    assign chain_cur   = item.restart ? iv_reg : chain_reg;
    assign counter_cur = item.restart ? '0 : counter_reg;

    always_comb
    begin
        logic [DATA_W-1:0] ks;
        logic [DATA_W-1:0] res;
        ks           = '0;
        res          = '0;
        chain_next   = chain_cur;
        counter_next = counter_cur;
        result_next.result_bytes = FULL_COUNT;
        case (mode_reg)
            MODE_CBC:
            begin
                res        = item.data_block ^ chain_cur ^ key_reg;
                chain_next = decrypt_reg ? item.data_block : res;
            end
            MODE_PCBC:
            begin
                res        = item.data_block ^ chain_cur ^ key_reg;
                chain_next = item.data_block ^ res;
            end
            MODE_CFB:
            begin
                ks  = chain_cur ^ key_reg;
                res = (item.data_block ^ ks) & byte_mask;
                // replace only the valid bytes, with ciphertext
                chain_next = (chain_cur & ~byte_mask)
                           | (decrypt_reg ? (item.data_block & byte_mask) : res);
                result_next.result_bytes = count_eff;
            end
            MODE_OFB:
            begin
                ks         = chain_cur ^ key_reg;
                chain_next = ks;
                res        = (item.data_block ^ ks) & byte_mask;
                result_next.result_bytes = count_eff;
            end
            MODE_CTR:
            begin
                ks           = iv_reg ^ counter_cur ^ key_reg;
                counter_next = counter_cur + DATA_W'(1);
                res          = (item.data_block ^ ks) & byte_mask;
                result_next.result_bytes = count_eff;
            end
            default:
            begin
                res = item.data_block ^ key_reg;
            end
        endcase
        result_next.result_block = res;
    end

    // Chain and counter advance only on an accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg   <= '0;
            counter_reg <= '0;
        end
        else if (accept)
        begin
            chain_reg   <= chain_next;
            counter_reg <= counter_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    a_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result_valid)
        else $error("accepted transaction produced no result");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.result_bytes >= COUNT_W'(1))
                      && (result.result_bytes <= FULL_COUNT))
        else $error("result byte count out of range");

    a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.result_bytes < FULL_COUNT)
        |-> ((result.result_block >> (8 * result.result_bytes)) == '0))
        else $error("result bytes past the count are not zero");

    a_block_mode_full: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (mode_reg != MODE_CFB) && (mode_reg != MODE_OFB)
        && (mode_reg != MODE_CTR)
        |=> (result.result_bytes == FULL_COUNT))
        else $error("block mode reported a partial block");

    a_counter_hold: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (mode_reg != MODE_CTR) && !item.restart |=> $stable(counter_reg))
        else $error("block counter moved outside counter mode");

endmodule
